// ===== rtl/core/dsps_pkg.sv =====
// Shared types and constants for the dual servo pulse sequencer.
// Holds the command codes, the phase action codes and the state flag struct.
// No dependencies.
`default_nettype none
package dsps_pkg;

	localparam int PHASE_W = 4;
	localparam int WIDTH_W = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_W-1:0] FRAME_CYCLE_RST = 16'd5000;
	localparam logic [CFG_W-1:0] FIRST_TOP_RST   = 16'd20000;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_CYCLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_TOP   = 1'd1;

	localparam logic [PHASE_W-1:0] PH_RAISE_A = 4'd0;
	localparam logic [PHASE_W-1:0] PH_LOWER_A = 4'd1;
	localparam logic [PHASE_W-1:0] PH_RAISE_B = 4'd2;
	localparam logic [PHASE_W-1:0] PH_LOWER_B = 4'd3;

	typedef struct packed {
		logic               level_a;
		logic               level_b;
		logic               running;
		logic [PHASE_W-1:0] phase;
	} flags_t;

endpackage
`default_nettype wire

// ===== rtl/core/dual_servo_pulse_sequencer.sv =====
// Top level of the dual servo pulse sequencer: state registers, result register, config port.
// Depends on dsps_pkg and dsps_step.
//
// Usage:
// Each input item carries a command (tick, start or stop) and the two pulse widths.
// A tick advances the counter while running; on a compare match the counter clears
// and the current phase action updates the servo levels and the compare top.
// Every accepted item yields exactly one result item: both servo levels, the phase
// whose action runs at the next match, and the running flag, all after the update.
// The result is valid in the cycle after the item is accepted.
// Throughput is one item per cycle while the output is not stalled; the state registers are updated
// at acceptance and the result register holds the new state.
// When the receiver stalls, the result stays in the output register and in_ready
// drops until it is taken, so no item is lost and the state holds.
// Reset clears the counter, phase, running flag and levels, loads the compare top
// from the first_top reset value and the frame cycle from its reset value.
// Configuration writes are taken in any cycle through cfg_we; a write to first_top
// also loads the compare top at once.
`default_nettype none
module dual_servo_pulse_sequencer import dsps_pkg::*; #(
	parameter int PHASE_COUNT = 9,
	parameter int TIMER_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           cmd,
	input  logic [WIDTH_W-1:0]   pulse_width_a,
	input  logic [WIDTH_W-1:0]   pulse_width_b,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 servo_a_level,
	output logic                 servo_b_level,
	output logic [PHASE_W-1:0]   phase_now,
	output logic                 is_running
);

	flags_t                flags_q;
	flags_t                flags_nxt;
	logic [TIMER_BITS-1:0] count_q;
	logic [TIMER_BITS-1:0] count_nxt;
	logic [TIMER_BITS-1:0] top_q;
	logic [TIMER_BITS-1:0] top_nxt;
	logic [TIMER_BITS-1:0] cfg_top;
	logic [TIMER_BITS-1:0] top_rst;
	logic [CFG_W-1:0]      frame_cycle_q;
	logic                  out_valid_q;
	logic                  in_acc;

	generate
		if (TIMER_BITS >= CFG_W) begin : g_wide
			assign cfg_top = {{(TIMER_BITS-CFG_W){1'b0}}, cfg_data};
			assign top_rst = {{(TIMER_BITS-CFG_W){1'b0}}, FIRST_TOP_RST};
		end else begin : g_narrow
			assign cfg_top = cfg_data[TIMER_BITS-1:0];
			assign top_rst = FIRST_TOP_RST[TIMER_BITS-1:0];
		end
	endgenerate

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	dsps_step #(
		.PHASE_COUNT (PHASE_COUNT),
		.TIMER_BITS  (TIMER_BITS)
	) u_step (
		.flags_cur     (flags_q),
		.count_cur     (count_q),
		.top_cur       (top_q),
		.cmd           (cmd),
		.pulse_width_a (pulse_width_a),
		.pulse_width_b (pulse_width_b),
		.frame_cycle   (frame_cycle_q),
		.flags_nxt     (flags_nxt),
		.count_nxt     (count_nxt),
		.top_nxt       (top_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q       <= '0;
			count_q       <= '0;
			top_q         <= top_rst;
			frame_cycle_q <= FRAME_CYCLE_RST;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_acc) begin
				flags_q <= flags_nxt;
				count_q <= count_nxt;
			end
			if (cfg_we && cfg_index == REG_FIRST_TOP) begin
				top_q <= cfg_top;
			end else if (in_acc) begin
				top_q <= top_nxt;
			end
			if (cfg_we && cfg_index == REG_FRAME_CYCLE) begin
				frame_cycle_q <= cfg_data;
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign servo_a_level = flags_q.level_a;
	assign servo_b_level = flags_q.level_b;
	assign phase_now     = flags_q.phase;
	assign is_running    = flags_q.running;

endmodule
`default_nettype wire

// ===== rtl/core/dsps_step.sv =====
// Next-state logic of the sequencer for one item: counter, compare match and phase action.
// Depends on dsps_pkg.
`default_nettype none
module dsps_step import dsps_pkg::*; #(
	parameter int PHASE_COUNT = 9,
	parameter int TIMER_BITS  = 16
) (
	input  flags_t                 flags_cur,
	input  logic [TIMER_BITS-1:0]  count_cur,
	input  logic [TIMER_BITS-1:0]  top_cur,
	input  logic [1:0]             cmd,
	input  logic [WIDTH_W-1:0]     pulse_width_a,
	input  logic [WIDTH_W-1:0]     pulse_width_b,
	input  logic [CFG_W-1:0]       frame_cycle,
	output flags_t                 flags_nxt,
	output logic [TIMER_BITS-1:0]  count_nxt,
	output logic [TIMER_BITS-1:0]  top_nxt
);

	logic [TIMER_BITS-1:0] wa_t;
	logic [TIMER_BITS-1:0] wb_t;
	logic [TIMER_BITS-1:0] frame_t;
	logic [PHASE_W:0]      phase_inc;
	logic [PHASE_W-1:0]    phase_adv;
	flags_t                flags_act;
	logic [TIMER_BITS-1:0] top_act;

	// Operands are brought to timer width so the low time wraps at the counter width.
	generate
		if (TIMER_BITS >= WIDTH_W) begin : g_wide
			assign wa_t    = {{(TIMER_BITS-WIDTH_W){1'b0}}, pulse_width_a};
			assign wb_t    = {{(TIMER_BITS-WIDTH_W){1'b0}}, pulse_width_b};
			assign frame_t = {{(TIMER_BITS-CFG_W){1'b0}}, frame_cycle};
		end else begin : g_narrow
			assign wa_t    = pulse_width_a[TIMER_BITS-1:0];
			assign wb_t    = pulse_width_b[TIMER_BITS-1:0];
			assign frame_t = frame_cycle[TIMER_BITS-1:0];
		end
	endgenerate

	assign phase_inc = {1'b0, flags_cur.phase} + {{PHASE_W{1'b0}}, 1'b1};
	assign phase_adv = (phase_inc >= (PHASE_W+1)'(PHASE_COUNT)) ? '0 : phase_inc[PHASE_W-1:0];

	always_comb begin
		flags_act       = flags_cur;
		top_act         = top_cur;
		flags_act.phase = phase_adv;
		case (flags_cur.phase)
			PH_RAISE_A: begin
				flags_act.level_a = 1'b1;
				top_act           = wa_t;
			end
			PH_LOWER_A: begin
				flags_act.level_a = 1'b0;
				top_act           = frame_t - wa_t;
			end
			PH_RAISE_B: begin
				flags_act.level_b = 1'b1;
				top_act           = wb_t;
			end
			PH_LOWER_B: begin
				flags_act.level_b = 1'b0;
				top_act           = frame_t - wb_t;
			end
			default: begin
				top_act = top_cur;
			end
		endcase
	end

	always_comb begin
		flags_nxt = flags_cur;
		count_nxt = count_cur;
		top_nxt   = top_cur;
		case (cmd)
			CMD_TICK: begin
				if (flags_cur.running) begin
					if (count_cur == top_cur) begin
						count_nxt = '0;
						flags_nxt = flags_act;
						top_nxt   = top_act;
					end else begin
						count_nxt = count_cur + {{(TIMER_BITS-1){1'b0}}, 1'b1};
					end
				end
			end
			CMD_START: begin
				count_nxt         = '0;
				flags_nxt.running = 1'b1;
			end
			CMD_STOP: begin
				flags_nxt.running = 1'b0;
			end
			default: begin
				flags_nxt = flags_cur;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/dsps_checker.sv =====
// Port-level checker for the dual servo pulse sequencer, bound to the top level.
// Depends on dsps_pkg.
`default_nettype none
module dsps_checker import dsps_pkg::*; #(
	parameter int PHASE_COUNT = 9
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [1:0]           cmd,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 servo_a_level,
	input logic                 servo_b_level,
	input logic [PHASE_W-1:0]   phase_now,
	input logic                 is_running
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(servo_a_level)
			&& $stable(servo_b_level) && $stable(phase_now) && $stable(is_running))
		else $error("result changed while stalled");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused without a stalled result");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_START |=> out_valid && is_running)
		else $error("start did not set running");

	a_stop_halts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_STOP |=> out_valid && !is_running)
		else $error("stop did not clear running");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, phase_now} < (PHASE_W+1)'(PHASE_COUNT))
		else $error("phase out of range");

endmodule

bind dual_servo_pulse_sequencer dsps_checker #(.PHASE_COUNT(PHASE_COUNT)) u_dsps_checker (.*);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for dual_servo_pulse_sequencer: directed idle commands, phase walks,
// register extremes and random traffic with idle gaps and output stalls, checked item by item.
// Depends on dsps_pkg and the dual_servo_pulse_sequencer RTL.
`default_nettype none
module tb;
	import dsps_pkg::*;

	localparam int PHASE_COUNT = 9;
	localparam int TIMER_BITS  = 16;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int CHUNKS = 12;
	localparam int CHUNK_ITEMS = 130;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           cmd;
	logic [WIDTH_W-1:0]   pulse_width_a;
	logic [WIDTH_W-1:0]   pulse_width_b;
	logic                 out_valid;
	logic                 out_ready;
	logic                 servo_a_level;
	logic                 servo_b_level;
	logic [PHASE_W-1:0]   phase_now;
	logic                 is_running;

	logic [TIMER_BITS-1:0] seq_ticks;
	logic [TIMER_BITS-1:0] seq_top;
	logic [TIMER_BITS-1:0] seq_frame;
	logic [PHASE_W-1:0]    seq_phase;
	logic                  seq_run;
	logic                  seq_pin_a;
	logic                  seq_pin_b;

	flags_t expected_levels[$];
	flags_t want;
	int     mismatches;
	int     cycles;
	bit     quiet;

	dual_servo_pulse_sequencer #(
		.PHASE_COUNT(PHASE_COUNT),
		.TIMER_BITS (TIMER_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.pulse_width_a(pulse_width_a),
		.pulse_width_b(pulse_width_b),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.servo_a_level(servo_a_level),
		.servo_b_level(servo_b_level),
		.phase_now    (phase_now),
		.is_running   (is_running)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	task automatic advance_sequencer(input logic [1:0] c, input logic [WIDTH_W-1:0] wa,
			input logic [WIDTH_W-1:0] wb);
		flags_t next_levels;
		case (c)
			CMD_TICK: begin
				if (seq_run) begin
					if (seq_ticks == seq_top) begin
						seq_ticks = '0;
						case (seq_phase)
							PH_RAISE_A: begin
								seq_pin_a = 1'b1;
								seq_top = wa;
							end
							PH_LOWER_A: begin
								seq_pin_a = 1'b0;
								seq_top = seq_frame - wa;
							end
							PH_RAISE_B: begin
								seq_pin_b = 1'b1;
								seq_top = wb;
							end
							PH_LOWER_B: begin
								seq_pin_b = 1'b0;
								seq_top = seq_frame - wb;
							end
							default: ;
						endcase
						seq_phase = (seq_phase == PHASE_W'(PHASE_COUNT - 1)) ? '0 :
							seq_phase + 1'b1;
					end else begin
						seq_ticks = seq_ticks + 1'b1;
					end
				end
			end
			CMD_START: begin
				seq_ticks = '0;
				seq_run = 1'b1;
			end
			CMD_STOP: seq_run = 1'b0;
			default: ;
		endcase
		next_levels.level_a = seq_pin_a;
		next_levels.level_b = seq_pin_b;
		next_levels.running = seq_run;
		next_levels.phase   = seq_phase;
		expected_levels.push_back(next_levels);
	endtask

	task automatic send_item(input logic [1:0] c, input logic [WIDTH_W-1:0] wa,
			input logic [WIDTH_W-1:0] wb);
		int unsigned gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= c;
		pulse_width_a <= wa;
		pulse_width_b <= wb;
		do @(posedge clk); while (!in_ready);
		advance_sequencer(c, wa, wb);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_levels.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_CYCLE)
			seq_frame = val;
		else
			seq_top = val;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_levels.size() == 0) begin
				$error("result item with no expectation pending");
				mismatches++;
			end else begin
				want = expected_levels.pop_front();
				if (servo_a_level !== want.level_a) begin
					$error("servo_a_level expected %0d got %0d", want.level_a, servo_a_level);
					mismatches++;
				end
				if (servo_b_level !== want.level_b) begin
					$error("servo_b_level expected %0d got %0d", want.level_b, servo_b_level);
					mismatches++;
				end
				if (phase_now !== want.phase) begin
					$error("phase_now expected %0d got %0d", want.phase, phase_now);
					mismatches++;
				end
				if (is_running !== want.running) begin
					$error("is_running expected %0d got %0d", want.running, is_running);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			stall = idle_len();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	task automatic test_idle_commands();
		send_item(CMD_STOP, 16'hFFFF, 16'hFFFF);
		send_item(CMD_TICK, 16'hFFFF, 16'h0000);
		send_item(CMD_UNUSED, 16'h0000, 16'hFFFF);
		send_item(CMD_STOP, 16'h0000, 16'h0000);
	endtask

	task automatic test_phase_walk();
		write_reg(REG_FRAME_CYCLE, 16'd0);
		write_reg(REG_FIRST_TOP, 16'd0);
		send_item(CMD_START, 16'h0000, 16'h0000);
		send_item(CMD_TICK, 16'h0000, 16'hFFFF);
		send_item(CMD_TICK, 16'hFFFF, 16'h0000);
		send_item(CMD_TICK, 16'h5555, 16'hAAAA);
		send_item(CMD_TICK, 16'hAAAA, 16'h0000);
		send_item(CMD_TICK, 16'hFFFF, 16'h0000);
		repeat (5) send_item(CMD_TICK, 16'($urandom), 16'($urandom));
		send_item(CMD_TICK, 16'd3, 16'hFFFF);
		send_item(CMD_TICK, 16'h1234, 16'h4321);
		send_item(CMD_START, 16'h0000, 16'h0000);
		send_item(CMD_TICK, 16'h0000, 16'h0000);
		send_item(CMD_STOP, 16'h0000, 16'h0000);
		send_item(CMD_TICK, 16'h0000, 16'h0000);
		send_item(CMD_START, 16'h0000, 16'h0000);
		repeat (3) send_item(CMD_TICK, 16'h0000, 16'h0000);
		send_item(CMD_TICK, 16'hFFFF, 16'h0000);
	endtask

	task automatic test_register_extremes();
		write_reg(REG_FRAME_CYCLE, 16'hFFFF);
		write_reg(REG_FIRST_TOP, 16'hFFFF);
		send_item(CMD_START, 16'h0000, 16'h0000);
		repeat (2) send_item(CMD_TICK, 16'hFFFF, 16'hFFFF);
		write_reg(REG_FIRST_TOP, 16'd0);
		send_item(CMD_START, 16'h0000, 16'h0000);
		send_item(CMD_TICK, 16'hFFFF, 16'h0000);
		send_item(CMD_TICK, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_random_traffic();
		logic [1:0]         c;
		logic [WIDTH_W-1:0] wa;
		logic [WIDTH_W-1:0] wb;
		int unsigned        r;
		int unsigned        pause_at;
		for (int chunk = 0; chunk < CHUNKS; chunk++) begin
			quiet = (chunk % 4 == 2);
			r = $urandom_range(0, 9);
			if (chunk == 0)
				write_reg(REG_FRAME_CYCLE, 16'd0);
			else if (chunk == 1 || r == 0)
				write_reg(REG_FRAME_CYCLE, 16'hFFFF);
			else if (r < 5)
				write_reg(REG_FRAME_CYCLE, 16'($urandom_range(0, 40)));
			else
				write_reg(REG_FRAME_CYCLE, 16'($urandom));
			if (chunk == 1)
				write_reg(REG_FIRST_TOP, 16'hFFFF);
			else if (chunk == 0 || r == 1)
				write_reg(REG_FIRST_TOP, 16'd0);
			else
				write_reg(REG_FIRST_TOP, 16'($urandom_range(0, 20)));
			pause_at = $urandom_range(20, CHUNK_ITEMS - 10);
			for (int j = 0; j < CHUNK_ITEMS; j++) begin
				if (j == pause_at)
					drain_results();
				r = $urandom_range(0, 99);
				if (j == 0)
					c = CMD_START;
				else if (seq_run)
					c = (r < 88) ? CMD_TICK : (r < 93) ? CMD_START :
						(r < 97) ? CMD_STOP : CMD_UNUSED;
				else
					c = (r < 40) ? CMD_START : (r < 75) ? CMD_TICK :
						(r < 90) ? CMD_STOP : CMD_UNUSED;
				wa = 16'($urandom);
				wb = 16'($urandom);
				if (c == CMD_TICK && seq_run && seq_ticks == seq_top &&
						$urandom_range(0, 39) != 0) begin
					case (seq_phase)
						PH_RAISE_A: wa = 16'($urandom_range(0, 12));
						PH_LOWER_A: wa = seq_frame - 16'($urandom_range(0, 12));
						PH_RAISE_B: wb = 16'($urandom_range(0, 12));
						PH_LOWER_B: wb = seq_frame - 16'($urandom_range(0, 12));
						default: ;
					endcase
				end
				send_item(c, wa, wb);
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		cmd           = CMD_TICK;
		pulse_width_a = '0;
		pulse_width_b = '0;
		mismatches    = 0;
		cycles        = 0;
		quiet         = 1'b0;
		seq_ticks     = '0;
		seq_top       = FIRST_TOP_RST;
		seq_frame     = FRAME_CYCLE_RST;
		seq_phase     = '0;
		seq_run       = 1'b0;
		seq_pin_a     = 1'b0;
		seq_pin_b     = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_idle_commands();
		test_phase_walk();
		test_register_extremes();
		test_random_traffic();
		drain_results();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/dsps_pkg.sv
rtl/core/dsps_step.sv
rtl/core/dual_servo_pulse_sequencer.sv
rtl/core/dsps_checker.sv
tb/tb.sv
